[design/uri_percent_decode_normalizer_assert.svh]
// Assertion macros for the URI percent-decode normalizer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef URI_PERCENT_DECODE_NORMALIZER_ASSERT_SVH
`define URI_PERCENT_DECODE_NORMALIZER_ASSERT_SVH

// Checked only while out of reset
`define UPN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define UPN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/upn_pkg.sv]
// Shared types, character codes and hex helpers for the URI normalizer.
// No dependencies.
package upn_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    // Escape state codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // Default depth of the result queue
    localparam int FIFO_DEPTH_DEF = 8;

    // One result byte with its end mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

    // Results produced by one input byte, slot 0 first
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_push;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= "0" && b <= "9") begin
            v = b - 8'h30;
        end else if (b >= "a" && b <= "f") begin
            v = b - 8'h61 + HEX_ALPHA_BASE;
        end else if (b >= "A" && b <= "F") begin
            v = b - 8'h41 + HEX_ALPHA_BASE;
        end
        return v[3:0];
    endfunction

endpackage

[design/upn_decode.sv]
// Input register, escape state and decode logic of the URI normalizer.
// Depends on upn_pkg; hands up to three results per byte to the queue.
module upn_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_room,
    output upn_pkg::t_push   o_push
);
    import upn_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic [7:0] r_held;
    logic       load_held;
    logic       consume;

    // Held item leaves the input register once the queue can take three results
    assign consume = r_in_valid && i_room;
    assign o_ready = !r_in_valid || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // Decode of the registered byte against the escape state
    always_comb begin
        t_result    idle_res;
        logic       idle_n;
        logic [1:0] idle_pend;
        idle_res  = '{data: r_in_byte, last: r_in_last};
        idle_n    = 1'b1;
        idle_pend = PEND_NONE;
        // Byte handled with nothing held
        if (r_in_byte == CH_PERCENT) begin
            if (!r_in_last) begin
                idle_n    = 1'b0;
                idle_pend = PEND_PCT;
            end
        end else if (r_in_byte == CH_BACKSLASH) begin
            idle_res.data = CH_SLASH;
        end

        o_push    = '0;
        n_pend    = idle_pend;
        load_held = 1'b0;
        case (r_pend)
            PEND_PCT: begin
                if (is_hex(r_in_byte)) begin
                    if (r_in_last) begin
                        o_push.cnt    = 2'd2;
                        o_push.res[0] = '{data: CH_PERCENT, last: 1'b0};
                        o_push.res[1] = '{data: r_in_byte, last: 1'b1};
                        n_pend        = PEND_NONE;
                    end else begin
                        load_held = 1'b1;
                        n_pend    = PEND_DIGIT;
                    end
                end else begin
                    o_push.cnt    = 2'd1 + {1'b0, idle_n};
                    o_push.res[0] = '{data: CH_PERCENT, last: 1'b0};
                    o_push.res[1] = idle_res;
                end
            end
            PEND_DIGIT: begin
                if (is_hex(r_in_byte)) begin
                    o_push.cnt    = 2'd1;
                    o_push.res[0] = '{data: {hex_value(r_held), hex_value(r_in_byte)},
                                      last: r_in_last};
                    n_pend        = PEND_NONE;
                end else begin
                    o_push.cnt    = 2'd2 + {1'b0, idle_n};
                    o_push.res[0] = '{data: CH_PERCENT, last: 1'b0};
                    o_push.res[1] = '{data: r_held, last: 1'b0};
                    o_push.res[2] = idle_res;
                end
            end
            default: begin
                o_push.cnt    = {1'b0, idle_n};
                o_push.res[0] = idle_res;
            end
        endcase
        if (!consume) begin
            o_push.cnt = 2'd0;
        end
    end

    // Escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
        end else if (consume) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && load_held) begin
            r_held <= r_in_byte;
        end
    end

endmodule

[design/upn_out_fifo.sv]
// Result queue of the URI normalizer: takes up to three results a cycle,
// gives one a cycle out while i_ready is high. Depends on upn_pkg.
module upn_out_fifo #(
    parameter int DEPTH = upn_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  upn_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic             o_last
);
    import upn_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 3);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            pop;

    // Pointer advance with wrap at DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] k);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(k);
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= ROOM_MAX);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd].data;
    assign o_last  = r_mem[r_rd].last;

    // Storage writes, one slot per produced result
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[wrap_add(r_wr, 2'(k))] <= i_push.res[k];
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= wrap_add(r_wr, i_push.cnt);
            r_rd    <= wrap_add(r_rd, {1'b0, pop});
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

endmodule

[design/uri_percent_decode_normalizer.sv]
// Top level of the URI percent-decode normalizer.
// Depends on upn_pkg, upn_decode, upn_out_fifo and the assertion header.
//
// Usage:
//   The slave channel takes one raw URI byte per transfer in s_axis_tdata,
//   with s_axis_tlast set on the final byte of the buffer. The master channel
//   gives the normalized bytes, one per transfer, with m_axis_tlast on the
//   final normalized byte. "%XY" with two hex digits becomes one byte, a
//   backslash becomes '/', broken escapes come out as they arrived.
//   An accepted byte is registered in the input register, decoded
//   combinationally from it and written into the result queue once the queue
//   has room for three results; m_axis_tvalid follows the queue's fill count.
//   Throughput: one input byte per cycle. A byte yields zero to three
//   results; the queue (FIFO_DEPTH entries) absorbs bursts and drains one
//   result per cycle while m_axis_tready is high, and the input register
//   waits while fewer than three entries are free.
//   Reset (i_rst_n low, synchronous) empties the queue and input register and
//   drops any held '%' or digit. When the receiver stalls, results stay in
//   the queue, and input flows until under three entries are free.
`include "uri_percent_decode_normalizer_assert.svh"

module uri_percent_decode_normalizer #(
    parameter int FIFO_DEPTH = upn_pkg::FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // end_of_buffer
);
    import upn_pkg::*;

    t_push push;
    logic  fifo_room;

    // Decode stage
    upn_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_room  (fifo_room),
        .o_push  (push)
    );

    // Result queue
    upn_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    // Results are only written when the queue has space for a full burst
    `UPN_ASSERT(a_push_needs_room, push.cnt != 2'd0 |-> fifo_room, "push without room")
    // A full-burst shortage means results are waiting
    `UPN_ASSERT(a_no_room_has_data, !fifo_room |-> m_axis_tvalid, "queue short of room but empty")
    // An empty queue with no write stays empty
    `UPN_ASSERT(a_empty_stays, !m_axis_tvalid && push.cnt == 2'd0 |=> !m_axis_tvalid,
        "result appeared without a write")

endmodule

[tb/sv/uri_percent_decode_normalizer_tb.sv]
// Self-checking testbench for the URI percent-decode normalizer.
// Depends on upn_pkg and the uri_percent_decode_normalizer top level; a queue-fed
// stream driver, a random-stall receiver and a byte-exact escape predictor.
module uri_percent_decode_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import upn_pkg::*;

    // One raw byte of a URI buffer with its end mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_raw_byte;

    localparam int IDLE_PCT     = 14;
    localparam int RANDOM_BYTES = 403;
    localparam int HOLD_START   = 60;
    localparam int HOLD_LEN     = 150;
    localparam int QUIET_START  = 300;
    localparam int QUIET_END    = 450;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;   // last_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic       m_axis_tlast;          // end_of_buffer

    // Stimulus, expected output bytes and escape tracking state
    t_raw_byte raw_byte_q[$];
    t_result   expected_out_q[$];
    t_raw_byte next_raw;
    logic [1:0] esc_state = PEND_NONE;
    logic [7:0] kept_digit = 8'd0;

    int  cyc = 0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;
    int  fail_cnt = 0;
    int  bytes_in = 0;
    int  bytes_out = 0;
    int  buffers_in = 0;
    int  escapes_decoded = 0;

    uri_percent_decode_normalizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Escape predictor
    // ---------------------------------------------------------------
    function automatic bit is_hex_char(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        return (b >= "0" && b <= "9") || (folded >= "a" && folded <= "f");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        if (b >= "0" && b <= "9") begin
            return 4'(b - "0");
        end
        return 4'(folded - "a" + HEX_ALPHA_BASE);
    endfunction

    task automatic emit_out(input logic [7:0] b, input logic eob);
        t_result r;
        r.data = b;
        r.last = eob;
        expected_out_q.insert(expected_out_q.size(), r);
    endtask

    // Byte seen with nothing held
    task automatic take_plain(input logic [7:0] b, input logic lst);
        if (b == CH_PERCENT && !lst) begin
            esc_state = PEND_PCT;
        end else begin
            esc_state = PEND_NONE;
            emit_out((b == CH_BACKSLASH) ? CH_SLASH : b, lst);
        end
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic lst);
        case (esc_state)
            PEND_PCT: begin
                if (is_hex_char(b)) begin
                    if (lst) begin
                        // buffer ends after one digit: both come out raw
                        emit_out(CH_PERCENT, 1'b0);
                        emit_out(b, 1'b1);
                        esc_state = PEND_NONE;
                    end else begin
                        kept_digit = b;
                        esc_state = PEND_DIGIT;
                    end
                end else begin
                    emit_out(CH_PERCENT, 1'b0);
                    take_plain(b, lst);
                end
            end
            PEND_DIGIT: begin
                if (is_hex_char(b)) begin
                    emit_out({hex_nibble(kept_digit), hex_nibble(b)}, lst);
                    escapes_decoded++;
                    esc_state = PEND_NONE;
                end else begin
                    emit_out(CH_PERCENT, 1'b0);
                    emit_out(kept_digit, 1'b0);
                    take_plain(b, lst);
                end
            end
            default: begin
                take_plain(b, lst);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------
    task automatic push_raw(input logic [7:0] b, input logic lst);
        t_raw_byte r;
        r.data = b;
        r.last = lst;
        raw_byte_q.insert(raw_byte_q.size(), r);
    endtask

    task automatic push_text(input string s, input bit ends_buffer);
        for (int i = 0; i < s.len(); i++) begin
            push_raw(s[i], ends_buffer && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    // Random buffers, mostly built from escapes with random digits
    task automatic build_random_buffers();
        logic [7:0] buf_bytes[$];
        int len;
        int pick;
        int target;
        target = raw_byte_q.size() + RANDOM_BYTES;
        while (raw_byte_q.size() < target) begin
            buf_bytes.delete();
            len = $urandom_range(1, 12);
            while (buf_bytes.size() < len) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    buf_bytes.insert(buf_bytes.size(), CH_PERCENT);
                    buf_bytes.insert(buf_bytes.size(), rand_hex_char());
                    buf_bytes.insert(buf_bytes.size(), rand_hex_char());
                end else if (pick < 55) begin
                    buf_bytes.insert(buf_bytes.size(), CH_PERCENT);
                end else if (pick < 70) begin
                    buf_bytes.insert(buf_bytes.size(), rand_hex_char());
                end else if (pick < 78) begin
                    buf_bytes.insert(buf_bytes.size(), CH_BACKSLASH);
                end else begin
                    buf_bytes.insert(buf_bytes.size(), 8'($urandom_range(255)));
                end
            end
            foreach (buf_bytes[i]) begin
                push_raw(buf_bytes[i], i == buf_bytes.size() - 1);
            end
        end
    endtask

    function automatic bit in_quiet();
        return cyc >= QUIET_START && cyc < QUIET_END;
    endfunction

    function automatic bit in_hold();
        return cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN;
    endfunction

    // ---------------------------------------------------------------
    // Sender: offers the next byte at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (raw_byte_q.size() > 0 &&
                (in_quiet() || in_hold() || $urandom_range(99) >= IDLE_PCT)) begin
                next_raw = raw_byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_raw.data;
                s_axis_tlast  <= next_raw.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (cyc == HOLD_START) begin
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= in_quiet() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each output transfer
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        in_taken = 1'b0;
        if (i_rst_n) begin
            cyc++;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_decode(s_axis_tdata, s_axis_tlast);
                in_taken = 1'b1;
                bytes_in++;
                if (s_axis_tlast) begin
                    buffers_in++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_out++;
                if (expected_out_q.size() == 0) begin
                    $error("unexpected output transfer: out_byte=%h end_of_buffer=%b",
                           m_axis_tdata, m_axis_tlast);
                    fail_cnt++;
                end else begin
                    exp_r = expected_out_q.pop_front();
                    if (m_axis_tdata !== exp_r.data) begin
                        $error("out_byte mismatch: expected %h, actual %h",
                               exp_r.data, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== exp_r.last) begin
                        $error("end_of_buffer mismatch: expected %b, actual %b",
                               exp_r.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial begin
        // Directed: full escapes at both output extremes, backslash,
        // a '%' breaking a pending '%', a backslash breaking a held digit,
        // a non-hex breaker, escape completed on the last byte, buffer ending
        // with a held digit, lone '%' at the end, input byte extremes
        push_text("%00%fF\\", 1'b0);
        push_text("%%4F", 1'b0);
        push_text("%4\\%G", 1'b1);
        push_text("%4F", 1'b1);
        push_text("%4", 1'b1);
        push_text("%", 1'b1);
        push_text("%4Z", 1'b1);
        push_raw(8'h00, 1'b0);
        push_raw(8'hFF, 1'b1);
        build_random_buffers();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (raw_byte_q.size() != 0 || s_axis_tvalid);
        while (expected_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers, checked %0d output bytes (%0d decoded escapes).",
                 bytes_in, buffers_in, bytes_out, escapes_decoded);
        $display("Included a %0d-cycle receiver hold-off and a stretch without stalls.",
                 HOLD_LEN);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200us;
        $display("Test completed with failures");
        $finish;
    end

endmodule
